/* design/dpwm_pkg.sv */
// -----------------------------------------------------------------------------
// dpwm_pkg : shared types and constants of the dual pwm timebase controller
// Item layouts, command and flag codes, and the control structs passed between
// the input stage, the gate unit, the timebase and the top level.
// -----------------------------------------------------------------------------
package dpwm_pkg;

   // default build constants
   localparam int COUNT_WIDTH_DEFAULT  = 16;
   localparam int DIVIDE_RATIO_DEFAULT = 10;
   localparam int NUM_TIMERS           = 3;

   // command codes
   localparam logic [1:0] CMD_TICK  = 2'd0;
   localparam logic [1:0] CMD_LOAD  = 2'd1;
   localparam logic [1:0] CMD_CLEAR = 2'd2;

   // countdown select codes
   localparam logic [1:0] TSEL_SMOKE = 2'd0;
   localparam logic [1:0] TSEL_SLEEP = 2'd1;
   localparam logic [1:0] TSEL_OIL   = 2'd2;

   // sticky flag bit positions
   localparam int FLAG_1MS   = 0;
   localparam int FLAG_10MS  = 1;
   localparam int FLAG_100MS = 2;
   localparam int FLAG_DUTY  = 3;
   localparam int FLAG_SHORT = 4;
   localparam int NUM_FLAGS  = 5;

   // phase value that marks a duty update
   localparam logic [7:0] DUTY_MARK_PHASE = 8'd5;

   // reset value of the phase maximum register
   localparam logic [7:0] PHASE_MAX_RESET = 8'd100;

   // incoming command item
   typedef struct packed {
      logic [1:0]  cmd;
      logic        pwm_enable;
      logic        both_channels;
      logic        load_select;
      logic [7:0]  duty_a;
      logic [7:0]  duty_b;
      logic        short_check_armed;
      logic        heater_active;
      logic [1:0]  timer_select;
      logic [15:0] timer_value;
      logic [4:0]  clear_mask;
   } dpwm_req_type;

   // outgoing status item
   typedef struct packed {
      logic        gate_a;
      logic        gate_b;
      logic        check_window;
      logic        short_error;
      logic        duty_update;
      logic        flag_1ms;
      logic        flag_10ms;
      logic        flag_100ms;
      logic [15:0] smoke_left;
      logic [15:0] sleep_left;
      logic [15:0] oil_left;
      logic [7:0]  phase;
   } dpwm_rsp_type;

   // per-item strobes decoded from the command
   typedef struct packed {
      logic advance;
      logic load;
      logic clear;
   } dpwm_ctl_type;

   // next state of the gate unit
   typedef struct packed {
      logic [7:0] phase;
      logic       gate_a;
      logic       gate_b;
      logic       window;
   } dpwm_pwm_view_type;

   // flag set requests from the gate unit
   typedef struct packed {
      logic duty_set;
      logic short_set;
   } dpwm_pwm_event_type;

   // flag set requests from the timebase
   typedef struct packed {
      logic set_1ms;
      logic set_10ms;
      logic set_100ms;
   } dpwm_tb_event_type;

endpackage

/* design/dpwm_in_reg.sv */
// -----------------------------------------------------------------------------
// dpwm_in_reg : input register of the controller
// Holds one accepted item until the processing stage takes it.
// -----------------------------------------------------------------------------
module dpwm_in_reg (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_valid,
   output logic                  req_stall,
   input  dpwm_pkg::dpwm_req_type req_item,
   input  logic                  out_free,
   output logic                  s1_valid,
   output dpwm_pkg::dpwm_req_type s1_item
);
   import dpwm_pkg::*;

   logic         valid_ff;
   logic         valid_in;
   dpwm_req_type item_ff;
   logic         accept;

   // stall only while an item waits and the next stage is blocked
   assign req_stall = valid_ff && !out_free;
   assign accept    = req_valid && !req_stall;

   // stage occupancy
   always_comb begin
      valid_in = accept || (valid_ff && !out_free);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   // payload capture
   always_ff @(posedge clock) begin
      if (accept) begin
         item_ff <= req_item;
      end
   end

   assign s1_valid = valid_ff;
   assign s1_item  = item_ff;

endmodule

/* design/dpwm_pwm_gate.sv */
// -----------------------------------------------------------------------------
// dpwm_pwm_gate : phase counter and gate compare unit
// Steps the wrapping phase on enabled ticks and updates the selected gates and the
// short-check window from the duty compares.
// -----------------------------------------------------------------------------
module dpwm_pwm_gate (
   input  logic                         clock,
   input  logic                         reset,
   input  dpwm_pkg::dpwm_ctl_type       ctl,
   input  dpwm_pkg::dpwm_req_type       item,
   input  logic [7:0]                   phase_max,
   output dpwm_pkg::dpwm_pwm_view_type  view_nxt,
   output dpwm_pkg::dpwm_pwm_event_type events
);
   import dpwm_pkg::*;

   logic [7:0] phase_ff;
   logic [7:0] phase_in;
   logic       gate_a_ff;
   logic       gate_a_in;
   logic       gate_b_ff;
   logic       gate_b_in;
   logic       window_ff;
   logic       window_in;

   logic       run;
   logic [7:0] phase_step;
   logic       drive_a;
   logic       drive_b;

   assign run     = ctl.advance && item.pwm_enable;
   assign drive_a = item.both_channels || !item.load_select;
   assign drive_b = item.both_channels || item.load_select;

   // wrapping phase step
   always_comb begin
      if (phase_ff < phase_max) begin
         phase_step = phase_ff + 8'd1;
      end else begin
         phase_step = 8'd0;
      end
   end

   // gate and window next values, channel b wins the window
   always_comb begin
      phase_in  = phase_ff;
      gate_a_in = gate_a_ff;
      gate_b_in = gate_b_ff;
      window_in = window_ff;
      if (run) begin
         phase_in = phase_step;
         if (drive_a) begin
            gate_a_in = (phase_step <= item.duty_a);
            window_in = (phase_step < item.duty_a);
         end
         if (drive_b) begin
            gate_b_in = (phase_step <= item.duty_b);
            window_in = (phase_step < item.duty_b);
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff  <= 8'd0;
         gate_a_ff <= 1'b0;
         gate_b_ff <= 1'b0;
         window_ff <= 1'b0;
      end else begin
         phase_ff  <= phase_in;
         gate_a_ff <= gate_a_in;
         gate_b_ff <= gate_b_in;
         window_ff <= window_in;
      end
   end

   // flag requests
   always_comb begin
      events.duty_set  = run && (phase_step == DUTY_MARK_PHASE);
      events.short_set = run && item.short_check_armed && !window_in;
   end

   always_comb begin
      view_nxt.phase  = phase_in;
      view_nxt.gate_a = gate_a_in;
      view_nxt.gate_b = gate_b_in;
      view_nxt.window = window_in;
   end

endmodule

/* design/dpwm_timebase.sv */
// -----------------------------------------------------------------------------
// dpwm_timebase : cascaded period dividers and saturating countdowns
// Three divide-by-ratio stages raise the 1 ms, 10 ms and 100 ms requests; the
// 100 ms step counts the smoke and sleep countdowns, and the oil one while the heater is active, down to zero.
// -----------------------------------------------------------------------------
module dpwm_timebase #(
   parameter int COUNT_WIDTH  = dpwm_pkg::COUNT_WIDTH_DEFAULT,
   parameter int DIVIDE_RATIO = dpwm_pkg::DIVIDE_RATIO_DEFAULT
) (
   input  logic                                               clock,
   input  logic                                               reset,
   input  dpwm_pkg::dpwm_ctl_type                             ctl,
   input  dpwm_pkg::dpwm_req_type                             item,
   output dpwm_pkg::dpwm_tb_event_type                        events,
   output logic [dpwm_pkg::NUM_TIMERS-1:0][COUNT_WIDTH-1:0]   count_nxt
);
   import dpwm_pkg::*;

   localparam int DIV_WIDTH = $clog2(DIVIDE_RATIO + 1);
   localparam logic [DIV_WIDTH-1:0] DIV_LIMIT = DIV_WIDTH'(DIVIDE_RATIO);
   localparam logic [DIV_WIDTH-1:0] DIV_RESTART = DIV_WIDTH'(1);

   logic [DIV_WIDTH-1:0] div_1ms_ff;
   logic [DIV_WIDTH-1:0] div_1ms_in;
   logic [DIV_WIDTH-1:0] div_10ms_ff;
   logic [DIV_WIDTH-1:0] div_10ms_in;
   logic [DIV_WIDTH-1:0] div_100ms_ff;
   logic [DIV_WIDTH-1:0] div_100ms_in;
   logic [NUM_TIMERS-1:0][COUNT_WIDTH-1:0] count_ff;
   logic [NUM_TIMERS-1:0][COUNT_WIDTH-1:0] count_in;

   logic                   wrap_1ms;
   logic                   wrap_10ms;
   logic                   wrap_100ms;
   logic [31:0]            load_wide;
   logic [COUNT_WIDTH-1:0] load_val;

   // divider cascade, each stage steps only when the one below wraps
   always_comb begin
      wrap_1ms   = ctl.advance && !(div_1ms_ff < DIV_LIMIT);
      wrap_10ms  = wrap_1ms && !(div_10ms_ff < DIV_LIMIT);
      wrap_100ms = wrap_10ms && !(div_100ms_ff < DIV_LIMIT);

      div_1ms_in   = div_1ms_ff;
      div_10ms_in  = div_10ms_ff;
      div_100ms_in = div_100ms_ff;
      if (ctl.advance) begin
         div_1ms_in = wrap_1ms ? DIV_RESTART : DIV_WIDTH'(div_1ms_ff + 1'b1);
      end
      if (wrap_1ms) begin
         div_10ms_in = wrap_10ms ? DIV_RESTART : DIV_WIDTH'(div_10ms_ff + 1'b1);
      end
      if (wrap_10ms) begin
         div_100ms_in = wrap_100ms ? DIV_RESTART : DIV_WIDTH'(div_100ms_ff + 1'b1);
      end
   end

   always_comb begin
      events.set_1ms   = wrap_1ms;
      events.set_10ms  = wrap_10ms;
      events.set_100ms = wrap_100ms;
   end

   // load value fitted to the countdown width
   assign load_wide = 32'(item.timer_value);
   assign load_val  = load_wide[COUNT_WIDTH-1:0];

   // countdown load and saturating decrement
   always_comb begin
      for (int i = 0; i < NUM_TIMERS; i++) begin
         count_in[i] = count_ff[i];
         if (ctl.load && (item.timer_select == 2'(i))) begin
            count_in[i] = load_val;
         end else if (wrap_100ms && (count_ff[i] != '0) &&
                      ((2'(i) != TSEL_OIL) || item.heater_active)) begin
            count_in[i] = COUNT_WIDTH'(count_ff[i] - 1'b1);
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         div_1ms_ff   <= '0;
         div_10ms_ff  <= '0;
         div_100ms_ff <= '0;
         count_ff     <= '0;
      end else begin
         div_1ms_ff   <= div_1ms_in;
         div_10ms_ff  <= div_10ms_in;
         div_100ms_ff <= div_100ms_in;
         count_ff     <= count_in;
      end
   end

   assign count_nxt = count_in;

endmodule

/* design/dual_pwm_timebase_controller_unit.sv */
// -----------------------------------------------------------------------------
// dual_pwm_timebase_controller_unit : dual pwm gate driver with timebase
// Path: an accepted item passes the input register, then the result register, held there under rsp_stall
// Throughput: one item per cycle while rsp_stall is low, one pass of logic between two one-deep registers
// Reset: synchronous, clears valids, counters and flags, sets the phase maximum to 100
// -----------------------------------------------------------------------------
module dual_pwm_timebase_controller_unit #(
   parameter int COUNT_WIDTH  = dpwm_pkg::COUNT_WIDTH_DEFAULT,
   parameter int DIVIDE_RATIO = dpwm_pkg::DIVIDE_RATIO_DEFAULT
) (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   req_valid,
   output logic                   req_stall,
   input  dpwm_pkg::dpwm_req_type req_item,
   output logic                   rsp_valid,
   input  logic                   rsp_stall,
   output dpwm_pkg::dpwm_rsp_type rsp_item,
   input  logic                   csr_valid,
   output logic                   csr_ready,
   input  logic [7:0]             csr_data
);
   import dpwm_pkg::*;

   logic                 s1_valid;
   dpwm_req_type         s1_item;
   logic                 out_free;
   logic                 fire;
   dpwm_ctl_type         ctl;
   dpwm_pwm_view_type    pwm_nxt;
   dpwm_pwm_event_type   pwm_events;
   dpwm_tb_event_type    tb_events;
   logic [NUM_TIMERS-1:0][COUNT_WIDTH-1:0] count_nxt;
   logic [NUM_TIMERS-1:0][31:0]            count_wide;

   logic [7:0]           phase_max_ff;
   logic                 started_ff;
   logic                 started_in;
   logic [NUM_FLAGS-1:0] flags_ff;
   logic [NUM_FLAGS-1:0] flags_in;
   logic [NUM_FLAGS-1:0] flags_set;
   logic [NUM_FLAGS-1:0] flags_clr;
   logic                 out_valid_ff;
   logic                 out_valid_in;
   dpwm_rsp_type         out_item_ff;
   dpwm_rsp_type         out_item_in;

   // configuration register, always ready
   assign csr_ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_max_ff <= PHASE_MAX_RESET;
      end else if (csr_valid && csr_ready) begin
         phase_max_ff <= csr_data;
      end
   end

   // input register
   dpwm_in_reg u_in_reg (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .req_item  (req_item),
      .out_free  (out_free),
      .s1_valid  (s1_valid),
      .s1_item   (s1_item)
   );

   // an item is processed when the result register can take it
   assign out_free = !out_valid_ff || !rsp_stall;
   assign fire     = s1_valid && out_free;

   // command decode, the very first tick only marks the start
   always_comb begin
      ctl.advance = fire && (s1_item.cmd == CMD_TICK) && started_ff;
      ctl.load    = fire && (s1_item.cmd == CMD_LOAD);
      ctl.clear   = fire && (s1_item.cmd == CMD_CLEAR);
      started_in  = started_ff || (fire && (s1_item.cmd == CMD_TICK));
   end

   dpwm_pwm_gate u_pwm_gate (
      .clock     (clock),
      .reset     (reset),
      .ctl       (ctl),
      .item      (s1_item),
      .phase_max (phase_max_ff),
      .view_nxt  (pwm_nxt),
      .events    (pwm_events)
   );

   dpwm_timebase #(
      .COUNT_WIDTH  (COUNT_WIDTH),
      .DIVIDE_RATIO (DIVIDE_RATIO)
   ) u_timebase (
      .clock     (clock),
      .reset     (reset),
      .ctl       (ctl),
      .item      (s1_item),
      .events    (tb_events),
      .count_nxt (count_nxt)
   );

   // sticky flags
   always_comb begin
      flags_set             = '0;
      flags_set[FLAG_1MS]   = tb_events.set_1ms;
      flags_set[FLAG_10MS]  = tb_events.set_10ms;
      flags_set[FLAG_100MS] = tb_events.set_100ms;
      flags_set[FLAG_DUTY]  = pwm_events.duty_set;
      flags_set[FLAG_SHORT] = pwm_events.short_set;
      flags_clr = ctl.clear ? s1_item.clear_mask : '0;
      flags_in  = (flags_ff | flags_set) & ~flags_clr;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         started_ff <= 1'b0;
         flags_ff   <= '0;
      end else begin
         started_ff <= started_in;
         flags_ff   <= flags_in;
      end
   end

   // countdowns shown at 16 bits
   always_comb begin
      for (int i = 0; i < NUM_TIMERS; i++) begin
         count_wide[i] = 32'(count_nxt[i]);
      end
   end

   // result register
   always_comb begin
      out_item_in = out_item_ff;
      if (fire) begin
         out_item_in.gate_a       = pwm_nxt.gate_a;
         out_item_in.gate_b       = pwm_nxt.gate_b;
         out_item_in.check_window = pwm_nxt.window;
         out_item_in.short_error  = flags_in[FLAG_SHORT];
         out_item_in.duty_update  = flags_in[FLAG_DUTY];
         out_item_in.flag_1ms     = flags_in[FLAG_1MS];
         out_item_in.flag_10ms    = flags_in[FLAG_10MS];
         out_item_in.flag_100ms   = flags_in[FLAG_100MS];
         out_item_in.smoke_left   = count_wide[TSEL_SMOKE][15:0];
         out_item_in.sleep_left   = count_wide[TSEL_SLEEP][15:0];
         out_item_in.oil_left     = count_wide[TSEL_OIL][15:0];
         out_item_in.phase        = pwm_nxt.phase;
      end
      out_valid_in = fire || (out_valid_ff && rsp_stall);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff <= 1'b0;
      end else begin
         out_valid_ff <= out_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      out_item_ff <= out_item_in;
   end

   assign rsp_valid = out_valid_ff;
   assign rsp_item  = out_item_ff;

endmodule

/* design/dpwm_checker.sv */
// -----------------------------------------------------------------------------
// dpwm_checker : port level checks of the dual pwm timebase controller
// Watches the item channels and the configuration port from outside.
// -----------------------------------------------------------------------------
module dpwm_checker (
   input logic                   clock,
   input logic                   reset,
   input logic                   req_valid,
   input logic                   req_stall,
   input logic                   rsp_valid,
   input logic                   rsp_stall,
   input dpwm_pkg::dpwm_rsp_type rsp_item,
   input logic                   csr_valid,
   input logic                   csr_ready
);
   import dpwm_pkg::*;

   logic req_take;

   assign req_take = req_valid && !req_stall;

   // nothing is offered straight after reset
   a_reset_empty: assert property (@(posedge clock)
      reset |=> !rsp_valid)
      else $error("result offered after reset");

   // a held result keeps its value
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp_item))
      else $error("stalled result changed or dropped");

   // the input side only backs up when the result side is stalled
   a_stall_source: assert property (@(posedge clock) disable iff (reset)
      req_stall |-> rsp_stall)
      else $error("input stalled without result stall");

   // no result appears without an accepted item behind it
   a_no_invented: assert property (@(posedge clock) disable iff (reset)
      !rsp_valid && !req_take && !$past(req_take) |=> !rsp_valid)
      else $error("result without an accepted item");

   // configuration writes are never refused
   a_csr_ready: assert property (@(posedge clock) disable iff (reset)
      csr_valid |-> csr_ready)
      else $error("configuration write refused");

endmodule

bind dual_pwm_timebase_controller_unit dpwm_checker u_dpwm_checker (.*);

/* tb/dual_pwm_timebase_controller_unit_tb.sv */
`timescale 1ns / 1ps
// -----------------------------------------------------------------------------
// dual_pwm_timebase_controller_unit_tb : self-checking bench for the pwm timebase
// Drives tick, countdown load, clear and spare commands through the item
// channel, mirrors the gate, divider and countdown state in a scoreboard
// and checks every status item field by field under random idling on both
// sides and several phase maximum settings.
// -----------------------------------------------------------------------------
module dual_pwm_timebase_controller_unit_tb;
   import dpwm_pkg::*;

   // command and select codes that the package leaves unnamed
   localparam logic [1:0] CMD_SPARE = 2'd3;
   localparam logic [1:0] TSEL_NONE = 2'd3;

   // scoreboard: mirrors the block state and holds the status items due
   class dpwm_status_checker;
      logic [7:0]   phase_max;
      logic         started;
      logic [7:0]   phase;
      logic         gate_a;
      logic         gate_b;
      logic         window;
      logic [4:0]   flags;
      int unsigned  divider [3];
      logic [15:0]  countdown [NUM_TIMERS];
      dpwm_rsp_type status_due [$];
      int unsigned  mismatch_count;
      int unsigned  num_ticks, num_loads, num_clears, num_spare, num_100ms_steps;
      int unsigned  num_checked;

      function new();
         phase_max = PHASE_MAX_RESET;
         started = 1'b0;
         phase = '0;
         gate_a = 1'b0;
         gate_b = 1'b0;
         window = 1'b0;
         flags = '0;
         foreach (divider[k]) divider[k] = 0;
         foreach (countdown[k]) countdown[k] = '0;
         mismatch_count = 0;
         num_ticks = 0; num_loads = 0; num_clears = 0; num_spare = 0;
         num_100ms_steps = 0; num_checked = 0;
      endfunction

      function void set_phase_max(logic [7:0] value);
         phase_max = value;
      endfunction

      function int unsigned pending();
         return status_due.size();
      endfunction

      // one divide-by-ratio stage, indexed by its flag bit
      function bit step_divider(int stage);
         if (divider[stage] < DIVIDE_RATIO_DEFAULT) begin
            divider[stage]++;
            return 1'b0;
         end
         divider[stage] = 1;
         flags[stage] = 1'b1;
         return 1'b1;
      endfunction

      function void apply_tick(dpwm_req_type r);
         int ph;
         num_ticks++;
         // the first tick after reset only arms the block
         if (!started) begin
            started = 1'b1;
            return;
         end
         // phase counter and gate compares
         if (r.pwm_enable) begin
            phase = (phase < phase_max) ? phase + 8'd1 : 8'd0;
            ph = phase;
            if (r.both_channels || !r.load_select) begin
               gate_a = (ph <= int'(r.duty_a));
               window = (ph <= int'(r.duty_a) - 1);
            end
            if (r.both_channels || r.load_select) begin
               gate_b = (ph <= int'(r.duty_b));
               window = (ph <= int'(r.duty_b) - 1);
            end
            if (phase == DUTY_MARK_PHASE) flags[FLAG_DUTY] = 1'b1;
            if (r.short_check_armed && !window) flags[FLAG_SHORT] = 1'b1;
         end
         // cascaded dividers, the last one steps the countdowns
         if (step_divider(FLAG_1MS))
            if (step_divider(FLAG_10MS))
               if (step_divider(FLAG_100MS)) begin
                  num_100ms_steps++;
                  if (r.heater_active && countdown[TSEL_OIL] != '0)
                     countdown[TSEL_OIL]--;
                  if (countdown[TSEL_SMOKE] != '0) countdown[TSEL_SMOKE]--;
                  if (countdown[TSEL_SLEEP] != '0) countdown[TSEL_SLEEP]--;
               end
      endfunction

      // accepted command item: update the mirror and queue the status due
      function void note_command(dpwm_req_type r);
         dpwm_rsp_type want;
         case (r.cmd)
            CMD_TICK: apply_tick(r);
            CMD_LOAD: begin
               num_loads++;
               if (r.timer_select < NUM_TIMERS) countdown[r.timer_select] = r.timer_value;
            end
            CMD_CLEAR: begin
               num_clears++;
               flags = flags & ~r.clear_mask;
            end
            default: num_spare++;
         endcase
         want.gate_a       = gate_a;
         want.gate_b       = gate_b;
         want.check_window = window;
         want.short_error  = flags[FLAG_SHORT];
         want.duty_update  = flags[FLAG_DUTY];
         want.flag_1ms     = flags[FLAG_1MS];
         want.flag_10ms    = flags[FLAG_10MS];
         want.flag_100ms   = flags[FLAG_100MS];
         want.smoke_left   = countdown[TSEL_SMOKE];
         want.sleep_left   = countdown[TSEL_SLEEP];
         want.oil_left     = countdown[TSEL_OIL];
         want.phase        = phase;
         status_due.push_back(want);
      endfunction

      function void compare_field(string name, logic [15:0] want, logic [15:0] got);
         if (got !== want) begin
            mismatch_count++;
            $error("%s: expected %0d, got %0d", name, want, got);
         end
      endfunction

      // accepted status item: compare with the oldest one due
      function void check_status(dpwm_rsp_type got);
         dpwm_rsp_type want;
         if (status_due.size() == 0) begin
            mismatch_count++;
            $error("status item with none due: %h", got);
            return;
         end
         want = status_due.pop_front();
         num_checked++;
         compare_field("gate_a", 16'(want.gate_a), 16'(got.gate_a));
         compare_field("gate_b", 16'(want.gate_b), 16'(got.gate_b));
         compare_field("check_window", 16'(want.check_window), 16'(got.check_window));
         compare_field("short_error", 16'(want.short_error), 16'(got.short_error));
         compare_field("duty_update", 16'(want.duty_update), 16'(got.duty_update));
         compare_field("flag_1ms", 16'(want.flag_1ms), 16'(got.flag_1ms));
         compare_field("flag_10ms", 16'(want.flag_10ms), 16'(got.flag_10ms));
         compare_field("flag_100ms", 16'(want.flag_100ms), 16'(got.flag_100ms));
         compare_field("smoke_left", want.smoke_left, got.smoke_left);
         compare_field("sleep_left", want.sleep_left, got.sleep_left);
         compare_field("oil_left", want.oil_left, got.oil_left);
         compare_field("phase", 16'(want.phase), 16'(got.phase));
      endfunction
   endclass

   logic         clock = 1'b0;
   logic         reset = 1'b1;
   logic         req_valid = 1'b0;
   logic         req_stall;
   dpwm_req_type req_item = '0;
   logic         rsp_valid;
   logic         rsp_stall = 1'b0;
   dpwm_rsp_type rsp_item;
   logic         csr_valid = 1'b0;
   logic         csr_ready;
   logic [7:0]   csr_data = '0;

   int unsigned gap_pct = 0;
   int unsigned stall_pct = 0;

   dpwm_status_checker status_chk;

   dual_pwm_timebase_controller_unit uut (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .req_item  (req_item),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .rsp_item  (rsp_item),
      .csr_valid (csr_valid),
      .csr_ready (csr_ready),
      .csr_data  (csr_data)
   );

   // 20 ns clock
   always begin
      #10 clock = 1'b1;
      #10 clock = 1'b0;
   end

   // receiver stalls at random
   always @(negedge clock) begin
      rsp_stall <= ($urandom_range(99) < stall_pct);
   end

   // accepted command items
   always @(posedge clock) begin
      if (!reset && req_valid && !req_stall) status_chk.note_command(req_item);
   end

   // accepted status items
   always @(posedge clock) begin
      if (!reset && rsp_valid === 1'b1 && !rsp_stall) status_chk.check_status(rsp_item);
   end

   // hang guard
   initial begin
      #20_000_000;
      $display("Regression FAIL");
      $finish;
   end

   function automatic dpwm_req_type tick_cmd(logic en, logic both, logic sel,
                                             logic [7:0] da, logic [7:0] db, logic armed);
      dpwm_req_type r;
      r = '0;
      r.cmd = CMD_TICK;
      r.pwm_enable = en;
      r.both_channels = both;
      r.load_select = sel;
      r.duty_a = da;
      r.duty_b = db;
      r.short_check_armed = armed;
      r.heater_active = 1'b1;
      return r;
   endfunction

   function automatic dpwm_req_type load_cmd(logic [1:0] sel, logic [15:0] value);
      dpwm_req_type r;
      r = '0;
      r.cmd = CMD_LOAD;
      r.timer_select = sel;
      r.timer_value = value;
      return r;
   endfunction

   function automatic dpwm_req_type clear_cmd(logic [4:0] mask);
      dpwm_req_type r;
      r = '0;
      r.cmd = CMD_CLEAR;
      r.clear_mask = mask;
      return r;
   endfunction

   // duty values biased to the extremes and to the current phase maximum
   function automatic logic [7:0] pick_duty(int unsigned top);
      case ($urandom_range(4))
         0: return 8'd0;
         1: return 8'hFF;
         2: return 8'd1;
         3: return 8'(top - $urandom_range(2));
         default: return 8'($urandom_range(255));
      endcase
   endfunction

   // mostly ticks, with loads, clears and the spare code mixed in
   function automatic dpwm_req_type random_command(int unsigned top);
      dpwm_req_type r;
      int unsigned pick;
      pick = $urandom_range(99);
      if (pick < 85) r.cmd = CMD_TICK;
      else if (pick < 92) r.cmd = CMD_LOAD;
      else if (pick < 98) r.cmd = CMD_CLEAR;
      else r.cmd = CMD_SPARE;
      r.pwm_enable = ($urandom_range(99) < 90);
      r.both_channels = 1'($urandom_range(1));
      r.load_select = 1'($urandom_range(1));
      r.duty_a = pick_duty(top);
      r.duty_b = pick_duty(top);
      r.short_check_armed = 1'($urandom_range(1));
      r.heater_active = ($urandom_range(99) < 70);
      r.timer_select = ($urandom_range(99) < 5) ? TSEL_NONE : 2'($urandom_range(2));
      r.timer_value = $urandom_range(1) ? 16'($urandom_range(3)) : 16'($urandom_range(65535));
      r.clear_mask = 5'($urandom_range(31));
      return r;
   endfunction

   // offer one item, with random gaps ahead of it
   task automatic send_command(dpwm_req_type r);
      while ($urandom_range(99) < gap_pct) begin
         req_valid <= 1'b0;
         @(negedge clock);
      end
      req_valid <= 1'b1;
      req_item <= r;
      @(posedge clock);
      while (req_stall) @(posedge clock);
      @(negedge clock);
   endtask

   // hold off the sender until every status item due has come
   task automatic wait_all_results();
      req_valid <= 1'b0;
      @(negedge clock);
      while (status_chk.pending() != 0) @(negedge clock);
   endtask

   task automatic write_phase_max(logic [7:0] value);
      csr_valid <= 1'b1;
      csr_data <= value;
      @(posedge clock);
      while (!csr_ready) @(posedge clock);
      status_chk.set_phase_max(value);
      @(negedge clock);
      csr_valid <= 1'b0;
   endtask

   initial begin
      int unsigned plan_max [6];
      int unsigned plan_len [6];
      dpwm_req_type r;
      int p, i;
      status_chk = new();
      plan_max = '{255, 1, 0, 2, $urandom_range(3, 254), PHASE_MAX_RESET};
      plan_len = '{400, 150, 100, 200, 300, 300};

      repeat (7) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;
      @(negedge clock);

      // sender idles lightly, receiver heavily
      gap_pct = 19;
      stall_pct = 69;
      write_phase_max(PHASE_MAX_RESET);

      // directed: swallowed first tick, zero duties, single channels, duty mark
      send_command(tick_cmd(1'b1, 1'b1, 1'b0, 8'hFF, 8'hFF, 1'b1));
      send_command(tick_cmd(1'b1, 1'b1, 1'b0, 8'd0, 8'd0, 1'b1));
      send_command(tick_cmd(1'b1, 1'b0, 1'b0, 8'd1, 8'hFF, 1'b0));
      send_command(tick_cmd(1'b1, 1'b0, 1'b1, 8'd0, 8'hFF, 1'b0));
      send_command(tick_cmd(1'b1, 1'b1, 1'b1, 8'd4, 8'd5, 1'b1));
      send_command(tick_cmd(1'b1, 1'b1, 1'b0, 8'hFF, 8'd0, 1'b0));
      send_command(tick_cmd(1'b0, 1'b1, 1'b0, 8'd0, 8'd0, 1'b1));
      // countdown loads, including the unused select
      send_command(load_cmd(TSEL_SMOKE, 16'hFFFF));
      send_command(load_cmd(TSEL_SLEEP, 16'd1));
      send_command(load_cmd(TSEL_OIL, 16'd2));
      send_command(load_cmd(TSEL_NONE, 16'h5A5A));
      // clears: one bit, none, all
      send_command(clear_cmd(5'b10000));
      send_command(clear_cmd(5'b00000));
      send_command(clear_cmd(5'b11111));
      // spare command with every other bit set
      r = '1;
      r.cmd = CMD_SPARE;
      send_command(r);
      // duty a equal to the phase and duty b one above it
      for (i = 0; i < 8; i++)
         send_command(tick_cmd(1'b1, 1'b1, 1'(i), 8'(i + 6), 8'(i + 7), 1'(i)));

      // random phases over several phase maximum settings
      for (p = 0; p < 6; p++) begin
         wait_all_results();
         if (p == 2) begin
            gap_pct = 69;
            stall_pct = 19;
         end
         if (p == 4) begin
            gap_pct = 0;
            stall_pct = 0;
         end
         write_phase_max(8'(plan_max[p]));
         for (i = 0; i < plan_len[p]; i++) begin
            if (p == 0 && i == plan_len[p] / 2) wait_all_results();
            send_command(random_command(plan_max[p]));
         end
      end

      wait_all_results();
      repeat (8) @(negedge clock);

      $display("covered %0d ticks, %0d loads, %0d clears, %0d spare commands",
               status_chk.num_ticks, status_chk.num_loads, status_chk.num_clears,
               status_chk.num_spare);
      $display("checked %0d status items over 7 phase maximum settings, %0d 100 ms steps",
               status_chk.num_checked, status_chk.num_100ms_steps);
      if (status_chk.mismatch_count == 0 && status_chk.pending() == 0) begin
         $display("Regression PASS");
      end else begin
         $display("Regression FAIL");
      end
      $finish;
   end

endmodule

/* sim.f */
design/dpwm_pkg.sv
design/dpwm_in_reg.sv
design/dpwm_pwm_gate.sv
design/dpwm_timebase.sv
design/dual_pwm_timebase_controller_unit.sv
design/dpwm_checker.sv
tb/dual_pwm_timebase_controller_unit_tb.sv
